// ===== rtl/dtrb_pkg.sv =====
// Shared types and constants for the DMA transmit ring buffer.
// No dependencies; used by the controller, the datapath and the top level.
package dtrb_pkg;

   // Fixed width of positions and counts on the result channel
   localparam int POS_W = 9;

   // Request kinds carried with each input beat
   typedef enum logic [1:0] {
      MODE_WRITE    = 2'd0,
      MODE_COMPLETE = 2'd1,
      MODE_FAIL     = 2'd2,
      MODE_READ     = 2'd3
   } mode_type;

   // Controller states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the accepted request beat
      logic execute;   // apply the latched request and load the result register
   } cmd_type;

endpackage

// ===== rtl/dma_tx_ring_buffer.sv =====
// DMA transmit ring buffer, top level.
// Request channel (req_*): one beat per message byte, completion, failure or
// DMA byte read; the kind is in req_tuser, the last byte of a message is marked
// by req_tlast. Result channel (rsp_*): exactly one beat per request beat, in
// order, carrying status, an optional chunk request (start and length, cut at
// the store end), read data, busy, bytes held and the running drop count.
// Timing: a beat is accepted in the idle state and applied in the execute step
// that follows once the result register is free, so the block takes no new beat
// before the last one is executed; this is set by the capture and execute steps
// of the controller around the single-port byte store. The result is registered
// on execute. The next request is accepted while a result still waits;
// its execute step holds until the result register is taken, so a stalled
// receiver stops the request side after one buffered beat.
// Reset clears pointers, busy, chunk length, drop count and discard state; the
// byte store itself is not cleared and has no clearing pass, so a position
// must be written before the DMA reads it.
// Depends on dtrb_pkg, dtrb_ctrl and dtrb_datapath.
module dma_tx_ring_buffer #(
   parameter int BUFFER_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], message_length[23:8],
                                    // read_index[32:24], zero[39:33]
   input  logic [2:0]  req_tuser,   // mode[1:0], first_of_message[2]
   input  logic        req_tlast,   // last_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // status[0], start_valid[1], start_index[10:2],
                                    // start_length[19:11], read_data[27:20],
                                    // busy_flag[28], used_count[37:29],
                                    // drop_total[69:38], zero[71:70]
);

   dtrb_pkg::cmd_type cmd;

   logic                        status, start_valid, busy_flag;
   logic [dtrb_pkg::POS_W-1:0]  start_index, start_length, used_count;
   logic [7:0]                  read_data;
   logic [31:0]                 drop_total;

   dtrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dtrb_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_mode             (req_tuser[1:0]),
      .req_data_byte        (req_tdata[7:0]),
      .req_message_length   (req_tdata[23:8]),
      .req_first_of_message (req_tuser[2]),
      .req_last_of_message  (req_tlast),
      .req_read_index       (req_tdata[32:24]),
      .rsp_status           (status),
      .rsp_start_valid      (start_valid),
      .rsp_start_index      (start_index),
      .rsp_start_length     (start_length),
      .rsp_read_data        (read_data),
      .rsp_busy_flag        (busy_flag),
      .rsp_used_count       (used_count),
      .rsp_drop_total       (drop_total)
   );

   // Pack the result beat, first field lowest
   assign rsp_tdata = {2'b00, drop_total, used_count, busy_flag, read_data,
                       start_length, start_index, start_valid, status};

`ifndef NO_ASSERTIONS
   // An accepted beat moves the controller into its execute step
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted twice without an execute step");

   // A requested chunk always leaves the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[28])
      else $error("chunk requested while busy flag is clear");

   // A new result appears only after an execute step
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised without an execute step");
`endif

endmodule

// ===== rtl/dtrb_ctrl.sv =====
// Sequencing controller for the DMA transmit ring buffer.
// Depends on dtrb_pkg; drives the capture and execute commands of dtrb_datapath.
module dtrb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output dtrb_pkg::cmd_type cmd
);

   dtrb_pkg::state_type state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_free;

   // The result register can take a new beat when empty or being emptied
   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == dtrb_pkg::ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   // Step between capture and execute; hold in execute while the result waits
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      case (state_ff)
         dtrb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = dtrb_pkg::ST_EXEC;
            end
         end
         dtrb_pkg::ST_EXEC: begin
            if (out_free) begin
               cmd.execute  = 1'b1;
               out_valid_in = 1'b1;
               state_in     = dtrb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in     = dtrb_pkg::ST_IDLE;
            out_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtrb_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/dtrb_datapath.sv =====
// Datapath of the DMA transmit ring buffer: pointers, drop counter, byte store
// and result register. Depends on dtrb_pkg; commanded by dtrb_ctrl.
module dtrb_datapath #(
   parameter int BUFFER_DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dtrb_pkg::cmd_type            cmd,
   input  logic [1:0]                   req_mode,
   input  logic [7:0]                   req_data_byte,
   input  logic [15:0]                  req_message_length,
   input  logic                         req_first_of_message,
   input  logic                         req_last_of_message,
   input  logic [8:0]                   req_read_index,
   output logic                         rsp_status,
   output logic                         rsp_start_valid,
   output logic [dtrb_pkg::POS_W-1:0]   rsp_start_index,
   output logic [dtrb_pkg::POS_W-1:0]   rsp_start_length,
   output logic [7:0]                   rsp_read_data,
   output logic                         rsp_busy_flag,
   output logic [dtrb_pkg::POS_W-1:0]   rsp_used_count,
   output logic [31:0]                  rsp_drop_total
);

   localparam int PTR_W  = $clog2(BUFFER_DEPTH);
   localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
   localparam int LEN_W  = (CNT_W > 16) ? CNT_W : 16;
   localparam int RIDX_W = (CNT_W > 9) ? CNT_W : 9;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
   localparam logic [PTR_W:0]   DEPTH_S = (PTR_W + 1)'(BUFFER_DEPTH);

   // Latched request beat
   dtrb_pkg::mode_type mode_ff;
   logic [7:0]         byte_ff;
   logic [15:0]        len_ff;
   logic               first_ff, last_ff;
   logic [8:0]         ridx_ff;

   // Ring state
   logic [PTR_W-1:0]   wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0]   rd_pos_ff, rd_pos_in;
   logic               in_flight_ff, in_flight_in;
   logic [PTR_W-1:0]   chunk_ff, chunk_in;
   logic [31:0]        drop_ff, drop_in;
   logic               discard_ff, discard_in;

   // Result register
   logic               status_ff, status_in;
   logic               start_ff, start_in;
   logic [PTR_W-1:0]   start_idx_ff, start_len_ff;
   logic               rd_en_ff, rd_en_in;
   logic [7:0]         rd_q_ff;

   // Byte store
   logic [7:0]         byte_store [BUFFER_DEPTH];
   logic               store_we;

   logic [CNT_W-1:0]   used_cnt, free_cnt;
   logic               drop_msg, discard_now;
   logic [31:0]        drop_add;
   logic [PTR_W:0]     wr_inc, rd_sum;
   logic [PTR_W-1:0]   wr_step, rd_step;
   logic               ts_req, ts_busy;
   logic [PTR_W-1:0]   ts_w, ts_r;
   logic [CNT_W-1:0]   ts_len;
   logic [PTR_W-1:0]   ridx_addr;

   // Latch the beat handed over by the controller
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= dtrb_pkg::mode_type'(req_mode);
         byte_ff  <= req_data_byte;
         len_ff   <= req_message_length;
         first_ff <= req_first_of_message;
         last_ff  <= req_last_of_message;
         ridx_ff  <= req_read_index;
      end
   end

   // Occupancy of the ring before the step
   always_comb begin
      if (wr_pos_ff >= rd_pos_ff) begin
         used_cnt = CNT_W'(wr_pos_ff) - CNT_W'(rd_pos_ff);
      end else begin
         used_cnt = DEPTH_C - CNT_W'(rd_pos_ff) + CNT_W'(wr_pos_ff);
      end
      free_cnt = DEPTH_C - CNT_W'(1) - used_cnt;
   end

   // Advanced positions, wrapped at the store end
   assign wr_inc  = {1'b0, wr_pos_ff} + (PTR_W + 1)'(1);
   assign wr_step = (wr_inc == DEPTH_S) ? '0 : wr_inc[PTR_W-1:0];
   assign rd_sum  = {1'b0, rd_pos_ff} + {1'b0, chunk_ff};
   assign rd_step = (rd_sum >= DEPTH_S) ? PTR_W'(rd_sum - DEPTH_S) : rd_sum[PTR_W-1:0];

   // Admission of a new message on its first byte
   assign drop_msg    = (len_ff != '0) && (LEN_W'(len_ff) > LEN_W'(free_cnt));
   assign discard_now = first_ff ? ((len_ff == '0) || drop_msg) : discard_ff;

   // Next ring state for the latched request
   always_comb begin
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      in_flight_in = in_flight_ff;
      chunk_in     = chunk_ff;
      discard_in   = discard_ff;
      drop_add     = '0;
      status_in    = 1'b0;
      rd_en_in     = 1'b0;
      store_we     = 1'b0;
      ts_req       = 1'b0;
      ts_busy      = in_flight_ff;
      ts_w         = wr_pos_ff;
      ts_r         = rd_pos_ff;
      case (mode_ff)
         dtrb_pkg::MODE_WRITE: begin
            if (first_ff && drop_msg) begin
               drop_add = 32'(len_ff);
            end
            if (discard_now) begin
               status_in  = 1'b1;
               discard_in = !last_ff;
            end else begin
               discard_in = 1'b0;
               if (free_cnt == '0) begin
                  // store full, e.g. more bytes than announced: drop this one
                  status_in = 1'b1;
                  drop_add  = 32'd1;
               end else begin
                  store_we  = 1'b1;
                  wr_pos_in = wr_step;
               end
               ts_req = last_ff;
               ts_w   = wr_pos_in;
            end
         end
         dtrb_pkg::MODE_COMPLETE: begin
            rd_pos_in    = rd_step;
            chunk_in     = '0;
            in_flight_in = 1'b0;
            ts_req       = 1'b1;
            ts_busy      = 1'b0;
            ts_r         = rd_step;
         end
         dtrb_pkg::MODE_FAIL: begin
            in_flight_in = 1'b0;
            chunk_in     = '0;
         end
         dtrb_pkg::MODE_READ: begin
            rd_en_in = (RIDX_W'(ridx_ff) < RIDX_W'(BUFFER_DEPTH));
         end
         default: begin
            rd_en_in = 1'b0;
         end
      endcase

      // Issue a contiguous chunk on a last byte or a completion when idle and data is held
      start_in = ts_req && !ts_busy && (ts_w != ts_r);
      if (ts_w > ts_r) begin
         ts_len = CNT_W'(ts_w) - CNT_W'(ts_r);
      end else begin
         ts_len = DEPTH_C - CNT_W'(ts_r);
      end
      if (start_in) begin
         in_flight_in = 1'b1;
         chunk_in     = ts_len[PTR_W-1:0];
      end
      drop_in = drop_ff + drop_add;
   end

   // Update ring state on execute
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         in_flight_ff <= 1'b0;
         chunk_ff     <= '0;
         drop_ff      <= '0;
         discard_ff   <= 1'b0;
      end else if (cmd.execute) begin
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         in_flight_ff <= in_flight_in;
         chunk_ff     <= chunk_in;
         drop_ff      <= drop_in;
         discard_ff   <= discard_in;
      end
   end

   // Load the result register on execute
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff    <= status_in;
         start_ff     <= start_in;
         start_idx_ff <= start_in ? ts_r : '0;
         start_len_ff <= start_in ? ts_len[PTR_W-1:0] : '0;
         rd_en_ff     <= rd_en_in;
      end
   end

   // Byte store: one write or one registered read per execute
   assign ridx_addr = PTR_W'(ridx_ff);

   always_ff @(posedge clock) begin
      if (cmd.execute && store_we) begin
         byte_store[wr_pos_ff] <= byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && rd_en_in) begin
         rd_q_ff <= byte_store[ridx_addr];
      end
   end

   // Ring state holds until the result is taken, so report it directly
   assign rsp_status       = status_ff;
   assign rsp_start_valid  = start_ff;
   assign rsp_start_index  = dtrb_pkg::POS_W'(start_idx_ff);
   assign rsp_start_length = dtrb_pkg::POS_W'(start_len_ff);
   assign rsp_read_data    = rd_en_ff ? rd_q_ff : 8'd0;
   assign rsp_busy_flag    = in_flight_ff;
   assign rsp_used_count   = dtrb_pkg::POS_W'(used_cnt);
   assign rsp_drop_total   = drop_ff;

endmodule

// ===== sim/dma_tx_ring_buffer_tb.sv =====
// Self-checking testbench for the DMA transmit ring buffer: a directed table,
// then random traffic, every result beat checked against its typed-in row or a shadow of the ring.
// Depends on dtrb_pkg and dma_tx_ring_buffer.
`timescale 1ns / 100ps

module dma_tx_ring_buffer_tb;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 7;
   localparam int DEPTH          = 512;
   localparam int IDX_W          = $clog2(DEPTH);
   localparam int RANDOM_ITEMS   = 1300;
   localparam int HOLDOFF_CYCLES = 120;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DIR_N          = 22;

   // One request beat, unpacked
   typedef struct packed {
      dtrb_pkg::mode_type         mode;
      logic [7:0]                 data_byte;
      logic [15:0]                msg_len;
      logic                       first;
      logic                       last;
      logic [dtrb_pkg::POS_W-1:0] ridx;
   } req_item_type;

   // One result beat, unpacked
   typedef struct packed {
      logic                       status;
      logic                       start_valid;
      logic [dtrb_pkg::POS_W-1:0] start_index;
      logic [dtrb_pkg::POS_W-1:0] start_length;
      logic [7:0]                 read_data;
      logic                       busy;
      logic [dtrb_pkg::POS_W-1:0] used;
      logic [31:0]                drop_total;
   } ring_result_type;

   typedef struct packed {
      req_item_type    req;
      logic            typed;   // use the typed-in result instead of the prediction
      ring_result_type want;
   } dir_row_type;

   // Directed rows, applied straight after reset
   localparam dir_row_type DIR_TABLE [DIR_N] = '{
      // completion and failure while idle: nothing held, nothing started
      '{'{dtrb_pkg::MODE_COMPLETE, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd0, 32'd0}},
      '{'{dtrb_pkg::MODE_FAIL, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd0, 32'd0}},
      // zero length on a first byte, then a discarded last byte
      '{'{dtrb_pkg::MODE_WRITE, 8'h11, 16'd0, 1'b1, 1'b0, 9'd0}, 1'b1,
        '{1'b1, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd0, 32'd0}},
      '{'{dtrb_pkg::MODE_WRITE, 8'h22, 16'hFFFF, 1'b0, 1'b1, 9'd0}, 1'b1,
        '{1'b1, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd0, 32'd0}},
      // largest length cannot fit: whole message dropped
      '{'{dtrb_pkg::MODE_WRITE, 8'h33, 16'hFFFF, 1'b1, 1'b1, 9'd0}, 1'b1,
        '{1'b1, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd0, 32'd65535}},
      // three byte message, chunk starts on its last byte
      '{'{dtrb_pkg::MODE_WRITE, 8'hFF, 16'd3, 1'b1, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd1, 32'd65535}},
      '{'{dtrb_pkg::MODE_WRITE, 8'h00, 16'h8000, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd2, 32'd65535}},
      '{'{dtrb_pkg::MODE_WRITE, 8'hA5, 16'd0, 1'b0, 1'b1, 9'd0}, 1'b1,
        '{1'b0, 1'b1, 9'd0, 9'd3, 8'h00, 1'b1, 9'd3, 32'd65535}},
      '{'{dtrb_pkg::MODE_READ, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'hFF, 1'b1, 9'd3, 32'd65535}},
      '{'{dtrb_pkg::MODE_READ, 8'h00, 16'd0, 1'b0, 1'b0, 9'd2}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'hA5, 1'b1, 9'd3, 32'd65535}},
      // failure keeps the data, the idle completion restarts the same chunk
      '{'{dtrb_pkg::MODE_FAIL, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd3, 32'd65535}},
      '{'{dtrb_pkg::MODE_COMPLETE, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b1, 9'd0, 9'd3, 8'h00, 1'b1, 9'd3, 32'd65535}},
      '{'{dtrb_pkg::MODE_COMPLETE, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd0, 32'd65535}},
      // single byte message
      '{'{dtrb_pkg::MODE_WRITE, 8'h5A, 16'd1, 1'b1, 1'b1, 9'h1FF}, 1'b1,
        '{1'b0, 1'b1, 9'd3, 9'd1, 8'h00, 1'b1, 9'd1, 32'd65535}},
      // message completes while busy: no new chunk until the completion
      '{'{dtrb_pkg::MODE_WRITE, 8'hC3, 16'd2, 1'b1, 1'b0, 9'd0}, 1'b0, '0},
      '{'{dtrb_pkg::MODE_WRITE, 8'h3C, 16'd0, 1'b0, 1'b1, 9'd0}, 1'b0, '0},
      '{'{dtrb_pkg::MODE_COMPLETE, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b1, 9'd4, 9'd2, 8'h00, 1'b1, 9'd2, 32'd65535}},
      '{'{dtrb_pkg::MODE_READ, 8'h00, 16'd0, 1'b0, 1'b0, 9'd5}, 1'b0, '0},
      // length over the free space
      '{'{dtrb_pkg::MODE_WRITE, 8'h77, 16'd600, 1'b1, 1'b0, 9'd0}, 1'b1,
        '{1'b1, 1'b0, 9'd0, 9'd0, 8'h00, 1'b1, 9'd2, 32'd66135}},
      '{'{dtrb_pkg::MODE_WRITE, 8'h88, 16'd0, 1'b0, 1'b1, 9'd0}, 1'b0, '0},
      '{'{dtrb_pkg::MODE_COMPLETE, 8'h00, 16'd0, 1'b0, 1'b0, 9'd0}, 1'b1,
        '{1'b0, 1'b0, 9'd0, 9'd0, 8'h00, 1'b0, 9'd0, 32'd66135}},
      '{'{dtrb_pkg::MODE_READ, 8'h00, 16'd0, 1'b0, 1'b0, 9'd4}, 1'b0, '0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;    // data_byte, message_length, read_index, zero
   logic [2:0]  req_tuser  = '0;    // mode, first_of_message
   logic        req_tlast  = 1'b0;  // last_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;          // status, start_valid, start_index, start_length,
                                    // read_data, busy_flag, used_count, drop_total

   // Shadow of the ring
   logic [7:0]  ring_store [DEPTH];
   bit          ring_written [DEPTH];
   int          wr_pos, rd_pos, chunk_len;
   bit          dma_busy, discard_on;
   logic [31:0] drop_count;

   ring_result_type pending_outcomes [$];
   int  mismatch_count, checked_count, counted, cycle_count;
   int  chunk_count, wrap_chunks, full_refusals;
   bit  quiet_tx, quiet_rx, long_holdoff_req;

   dma_tx_ring_buffer #(.BUFFER_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_outcomes.size());
         $display("status: fail");
         $finish;
      end
   end

   function automatic int ring_used();
      return (wr_pos >= rd_pos) ? wr_pos - rd_pos : DEPTH - rd_pos + wr_pos;
   endfunction

   function automatic int ring_free();
      return DEPTH - ring_used() - 1;
   endfunction

   // Request one contiguous chunk if idle and data is held
   function automatic void open_chunk(inout ring_result_type r);
      if (dma_busy || wr_pos == rd_pos)
         return;
      chunk_len        = (wr_pos > rd_pos) ? wr_pos - rd_pos : DEPTH - rd_pos;
      dma_busy         = 1'b1;
      r.start_valid    = 1'b1;
      r.start_index    = dtrb_pkg::POS_W'(rd_pos);
      r.start_length   = dtrb_pkg::POS_W'(chunk_len);
   endfunction

   // Apply one request to the shadow ring and return the result it causes
   function automatic ring_result_type ring_outcome(req_item_type it);
      ring_result_type r;
      r = '0;
      case (it.mode)
         dtrb_pkg::MODE_WRITE: begin
            if (it.first) begin
               if (it.msg_len == 16'd0) begin
                  discard_on = 1'b1;
               end else if (int'(it.msg_len) > ring_free()) begin
                  discard_on = 1'b1;
                  drop_count += 32'(it.msg_len);
               end else begin
                  discard_on = 1'b0;
               end
            end
            if (discard_on) begin
               r.status = 1'b1;
               if (it.last)
                  discard_on = 1'b0;
            end else begin
               if (ring_free() == 0) begin
                  r.status = 1'b1;
                  drop_count += 32'd1;
                  full_refusals++;
               end else begin
                  ring_store[IDX_W'(wr_pos)]   = it.data_byte;
                  ring_written[IDX_W'(wr_pos)] = 1'b1;
                  wr_pos = (wr_pos + 1) % DEPTH;
               end
               if (it.last)
                  open_chunk(r);
            end
         end
         dtrb_pkg::MODE_COMPLETE: begin
            rd_pos    = (rd_pos + chunk_len) % DEPTH;
            chunk_len = 0;
            dma_busy  = 1'b0;
            open_chunk(r);
         end
         dtrb_pkg::MODE_FAIL: begin
            dma_busy  = 1'b0;
            chunk_len = 0;
         end
         default: begin
            if (int'(it.ridx) < DEPTH)
               r.read_data = ring_store[IDX_W'(it.ridx)];
         end
      endcase
      r.busy       = dma_busy;
      r.used       = dtrb_pkg::POS_W'(ring_used());
      r.drop_total = drop_count;
      return r;
   endfunction

   // Find a store position written since reset, starting at a random point
   function automatic bit pick_written(output int idx);
      int origin;
      origin = $urandom_range(0, DEPTH - 1);
      idx = 0;
      for (int k = 0; k < DEPTH; k++) begin
         idx = (origin + k) % DEPTH;
         if (ring_written[IDX_W'(idx)])
            return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result %0d: %s expected %0h, got %0h", checked_count, name, want, seen);
      end
   endfunction

   // Offer one beat after a random gap, hold it until taken, then predict
   task automatic send_beat(input req_item_type it, input bit typed,
                            input ring_result_type want);
      int              gap;
      ring_result_type got;
      gap = quiet_tx ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, it.ridx, it.msg_len, it.data_byte};
      req_tuser  <= {it.first, it.mode};
      req_tlast  <= it.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = ring_outcome(it);
      pending_outcomes.push_back(typed ? want : got);
      counted++;
      if (got.start_valid) begin
         chunk_count++;
         if (int'(got.start_index) + int'(got.start_length) == DEPTH)
            wrap_chunks++;
      end
   endtask

   // Result side: random stalls, one long hold-off on request, check each beat
   initial begin : result_side
      int              stall;
      ring_result_type seen, want;
      while (reset) @(posedge clock);
      forever begin
         if (long_holdoff_req) begin
            long_holdoff_req = 1'b0;
            stall = HOLDOFF_CYCLES;
         end else begin
            if ($urandom_range(0, 31) == 0)
               quiet_rx = !quiet_rx;
            stall = quiet_rx ? 0 : $urandom_range(0, 8);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         seen.status       = rsp_tdata[0];
         seen.start_valid  = rsp_tdata[1];
         seen.start_index  = rsp_tdata[10:2];
         seen.start_length = rsp_tdata[19:11];
         seen.read_data    = rsp_tdata[27:20];
         seen.busy         = rsp_tdata[28];
         seen.used         = rsp_tdata[37:29];
         seen.drop_total   = rsp_tdata[69:38];
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result beat with nothing expected: %h", rsp_tdata);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(seen.status));
            check_field("start_valid", 32'(want.start_valid), 32'(seen.start_valid));
            check_field("start_index", 32'(want.start_index), 32'(seen.start_index));
            check_field("start_length", 32'(want.start_length), 32'(seen.start_length));
            check_field("read_data", 32'(want.read_data), 32'(seen.read_data));
            check_field("busy_flag", 32'(want.busy), 32'(seen.busy));
            check_field("used_count", 32'(want.used), 32'(seen.used));
            check_field("drop_total", want.drop_total, seen.drop_total);
         end
         checked_count++;
      end
   end

   // Request side: directed table, then random traffic
   initial begin : request_side
      req_item_type it;
      int           pick, len, nbytes, idx, nreads, lr, svc;
      bit           fill_phase, exact_fit, held_once, held_twice, drained;
      wr_pos     = 0;
      rd_pos     = 0;
      chunk_len  = 0;
      dma_busy   = 1'b0;
      discard_on = 1'b0;
      drop_count = '0;
      fill_phase = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_N; r++)
         send_beat(DIR_TABLE[r].req, DIR_TABLE[r].typed, DIR_TABLE[r].want);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         // long receiver hold-offs and one full drain along the way
         if (!held_once && counted >= 300) begin
            held_once = 1'b1;
            long_holdoff_req = 1'b1;
         end
         if (!held_twice && counted >= 1000) begin
            held_twice = 1'b1;
            long_holdoff_req = 1'b1;
         end
         if (!drained && counted >= 650) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_outcomes.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 31) == 0)
            quiet_tx = !quiet_tx;
         if ($urandom_range(0, 39) == 0)
            fill_phase = !fill_phase;
         svc  = fill_phase ? 2 : 25;
         pick = $urandom_range(0, 99);

         if (pick < 55) begin
            // well-formed message, sometimes too long, short, or over its length
            lr = $urandom_range(0, 99);
            exact_fit = 1'b0;
            if (lr < 4)
               len = 0;
            else if (lr < 10)
               len = $urandom_range(65535, ring_free() + 1);
            else if (lr < 16 && ring_free() <= 64) begin
               len = (ring_free() == 0) ? 1 : ring_free();
               exact_fit = 1'b1;
            end else if (lr < 80)
               len = $urandom_range(1, 24);
            else
               len = $urandom_range(25, 160);
            if (len == 0 || len > ring_free())
               nbytes = $urandom_range(1, 6);
            else if (exact_fit)
               nbytes = len + $urandom_range(1, 2);
            else if ($urandom_range(0, 99) < 8)
               nbytes = len + $urandom_range(1, 3);
            else if ($urandom_range(0, 99) < 5)
               nbytes = $urandom_range(1, len);
            else
               nbytes = len;
            for (int k = 0; k < nbytes; k++) begin
               it.mode      = dtrb_pkg::MODE_WRITE;
               it.data_byte = 8'($urandom);
               it.msg_len   = (k == 0) ? 16'(len) : 16'($urandom);
               it.first     = (k == 0);
               it.last      = (k == nbytes - 1);
               it.ridx      = dtrb_pkg::POS_W'($urandom);
               send_beat(it, 1'b0, '0);
            end
         end else if (pick < 55 + svc) begin
            // DMA service: fetch some chunk bytes, then complete or fail
            if (dma_busy) begin
               nreads = $urandom_range(0, 3);
               for (int k = 0; k < nreads; k++) begin
                  it = '0;
                  it.mode = dtrb_pkg::MODE_READ;
                  it.data_byte = 8'($urandom);
                  it.msg_len = 16'($urandom);
                  it.ridx = dtrb_pkg::POS_W'((rd_pos + $urandom_range(0, chunk_len - 1))
                                             % DEPTH);
                  send_beat(it, 1'b0, '0);
               end
               it = '0;
               it.mode = ($urandom_range(0, 99) < 90) ? dtrb_pkg::MODE_COMPLETE
                                                      : dtrb_pkg::MODE_FAIL;
            end else begin
               it = '0;
               it.mode = ($urandom_range(0, 99) < 80) ? dtrb_pkg::MODE_COMPLETE
                                                      : dtrb_pkg::MODE_FAIL;
            end
            it.ridx = dtrb_pkg::POS_W'($urandom);
            it.first = 1'($urandom);
            it.last = 1'($urandom);
            send_beat(it, 1'b0, '0);
         end else if (pick < 90) begin
            // read anywhere that has been written
            if (pick_written(idx)) begin
               it = '0;
               it.mode = dtrb_pkg::MODE_READ;
               it.ridx = dtrb_pkg::POS_W'(idx);
               it.data_byte = 8'($urandom);
               send_beat(it, 1'b0, '0);
            end
         end else begin
            // noise: any kind, any marks, any length
            it.mode      = dtrb_pkg::mode_type'($urandom_range(0, 3));
            it.data_byte = 8'($urandom);
            it.msg_len   = 16'($urandom);
            it.first     = 1'($urandom);
            it.last      = 1'($urandom);
            it.ridx      = dtrb_pkg::POS_W'($urandom);
            if (it.mode == dtrb_pkg::MODE_READ) begin
               if (pick_written(idx))
                  it.ridx = dtrb_pkg::POS_W'(idx);
               else
                  it.mode = dtrb_pkg::MODE_FAIL;
            end
            send_beat(it, 1'b0, '0);
         end
      end

      // Let the last results drain
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results, %0d mismatches; %0d chunks started, %0d cut at store end",
               checked_count, mismatch_count, chunk_count, wrap_chunks);
      $display("bytes refused on a full store: %0d; bytes counted as dropped: %0d",
               full_refusals, drop_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
